// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL; they compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ===== sv/dtvp_pkg.sv =====
package dtvp_pkg;

    localparam int YEAR_W   = 16;
    localparam int FIELD_W  = 8;
    localparam int MICRO_W  = 32;
    localparam int USEC_W   = 20;

    localparam int IN_DATA_W  = YEAR_W + 5 * FIELD_W + MICRO_W;
    localparam int DATE_W     = 32;
    localparam int DTIME_W    = 64;
    localparam int OUT_DATA_W = DATE_W + DTIME_W;

    localparam logic [YEAR_W-1:0]  YEAR_OFFSET = 16'd1900;
    localparam logic [YEAR_W-1:0]  YEAR_SMALL  = 16'd1000;
    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 16'd9999;
    localparam logic [5:0]         DATE_TAG    = 6'h3E;

    localparam logic [FIELD_W-1:0] MONTH_MAX  = 8'd12;
    localparam logic [FIELD_W-1:0] HOUR_MAX   = 8'd23;
    localparam logic [FIELD_W-1:0] MINUTE_MAX = 8'd59;
    localparam logic [FIELD_W-1:0] SECOND_MAX = 8'd59;

    // A 16-bit year is a multiple of 25 exactly when its product with the
    // inverse of 25 modulo 2^16 is at most floor(65535 / 25). Together with
    // the low bits this settles the century rules for 100 and 400.
    localparam logic [YEAR_W-1:0] INV25       = 16'd23593;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 16'((2 ** YEAR_W - 1) / 25);

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    typedef struct packed {
        logic                from_broken_down;
        logic [YEAR_W-1:0]   year;
        logic [FIELD_W-1:0]  month;
        logic [FIELD_W-1:0]  day;
        logic [FIELD_W-1:0]  hour;
        logic [FIELD_W-1:0]  minute;
        logic [FIELD_W-1:0]  second;
        logic [MICRO_W-1:0]  micro;
    } stamp_t;

    typedef struct packed {
        logic                is_valid;
        logic [DATE_W-1:0]   date_word;
        logic [DTIME_W-1:0]  datetime_word;
    } result_t;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        case (month)
            MONTH_FEB:                                  days = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
            default:                                    days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

// ===== sv/dtvp_check.sv =====
module dtvp_check (
    input  dtvp_pkg::stamp_t  stamp,
    output dtvp_pkg::result_t res
);

    logic [dtvp_pkg::YEAR_W-1:0]   year_adj;
    logic [dtvp_pkg::FIELD_W-1:0]  month_adj;
    logic [dtvp_pkg::YEAR_W-1:0]   inv_prod;
    logic                          div25;
    logic                          leap;
    logic [4:0]                    mdays;
    logic                          zero_date;
    logic                          month_ok;
    logic                          day_ok;
    logic                          time_ok;
    logic                          ok;

    always_comb
    begin
        if (stamp.from_broken_down && stamp.year != '0 && stamp.year < dtvp_pkg::YEAR_SMALL)
        begin
            year_adj = stamp.year + dtvp_pkg::YEAR_OFFSET;
        end
        else
        begin
            year_adj = stamp.year;
        end

        month_adj = stamp.from_broken_down ? stamp.month + 8'd1 : stamp.month;

        inv_prod = year_adj * dtvp_pkg::INV25;
        div25    = inv_prod <= dtvp_pkg::DIV25_LIMIT;
        leap     = (year_adj[1:0] == 2'b00) && (!div25 || year_adj[3:0] == 4'b0000);
        mdays    = dtvp_pkg::month_days(month_adj[3:0], leap);

        zero_date = (year_adj == '0) && (month_adj == '0) && (stamp.day == '0);
        month_ok  = (month_adj != '0) && (month_adj <= dtvp_pkg::MONTH_MAX);
        day_ok    = (stamp.day != '0) && (stamp.day <= {3'b000, mdays});
        time_ok   = (stamp.hour <= dtvp_pkg::HOUR_MAX)
                    && (stamp.minute <= dtvp_pkg::MINUTE_MAX)
                    && (stamp.second <= dtvp_pkg::SECOND_MAX);

        ok = (year_adj <= dtvp_pkg::YEAR_MAX) && (zero_date || (month_ok && day_ok)) && time_ok;

        res.is_valid = ok;
        if (ok)
        begin
            res.date_word = {year_adj, month_adj[3:0], stamp.day[5:0], dtvp_pkg::DATE_TAG};
            res.datetime_word = {year_adj, month_adj[3:0], stamp.day[5:0], stamp.hour[5:0],
                                 stamp.minute[5:0], stamp.second[5:0],
                                 stamp.micro[dtvp_pkg::USEC_W-1:0]};
        end
        else
        begin
            res.date_word     = '0;
            res.datetime_word = '0;
        end
    end

endmodule

// ===== sv/datetime_validate_and_pack.sv =====
// An accepted request is held in the input register, then checked into the result register.
// Throughput: one request per cycle while m_axis_tready is high; the input register and
// the result register each advance whenever the stage after them is empty or being taken.
// Reset clears both valid flags; the payload registers are not reset.
// The block keeps no state from one request to the next.
`include "assert_macros.svh"

module datetime_validate_and_pack (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // year_in, month_in, day_in, hour_in, minute_in, second_in, micro_in
    input  logic [dtvp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // from_broken_down
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // date_word, datetime_word
    output logic [dtvp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // is_valid
    output logic [0:0]                      m_axis_tuser
);

    logic              in_valid_reg;
    logic              in_valid_next;
    dtvp_pkg::stamp_t  in_stamp_reg;
    dtvp_pkg::stamp_t  in_stamp_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    dtvp_pkg::result_t out_res_reg;
    dtvp_pkg::result_t out_res_next;
    dtvp_pkg::stamp_t  s_stamp;
    dtvp_pkg::result_t check_res;
    logic              s_accept;
    logic              advance;

    assign s_stamp = {s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[23:16],
                      s_axis_tdata[31:24], s_axis_tdata[39:32], s_axis_tdata[47:40],
                      s_axis_tdata[55:48], s_axis_tdata[87:56]};

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    dtvp_check u_check (
        .stamp (in_stamp_reg),
        .res   (check_res)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_stamp_next  = in_stamp_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
            if (in_valid_reg)
            begin
                out_res_next = check_res;
            end
            in_valid_next = 1'b0;
        end
        if (s_accept)
        begin
            in_valid_next = 1'b1;
            in_stamp_next = s_stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_stamp_reg <= in_stamp_next;
        out_res_reg  <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.datetime_word, out_res_reg.date_word};
    assign m_axis_tuser  = out_res_reg.is_valid;

    `ASSERT_CLK(a_invalid_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    `ASSERT_NEXT(a_accept_loads, clk, rst_n, s_accept, in_valid_reg)
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, in_valid_reg && !advance, in_valid_reg && out_valid_reg)

endmodule
